// File: hw/rtl/kcs_pkg.sv
package kcs_pkg;

  localparam int MAX_KEEP = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEEP_BITS = 5;
  localparam int REG_INDEX_BITS = 1;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_TARGET = 1'b0,
    REG_KEEP   = 1'b1
  } kcs_reg_t;

  // One kept entry as it travels between neighboring cells.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] distance;
  } kcs_entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                  insert;
    logic                  drain;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] new_dist;
  } kcs_ctl_t;

endpackage

// File: hw/rtl/kcs_cell.sv
module kcs_cell (
  input  logic               clk,
  input  logic               rst,
  input  kcs_pkg::kcs_ctl_t  ctl,
  input  logic               in_limit,
  input  logic               prev_before,
  input  kcs_pkg::kcs_entry_t prev_ent,
  input  kcs_pkg::kcs_entry_t next_ent,
  output kcs_pkg::kcs_entry_t ent,
  output logic               ahead
);

  logic                          valid;
  logic [kcs_pkg::VALUE_BITS-1:0] value;
  logic [kcs_pkg::VALUE_BITS-1:0] distance;
  logic                          valid_eff;

  // Entries at or above the current keep count are treated as gone.
  assign valid_eff = valid && in_limit;

  // A new word goes ahead of this entry only on a strictly smaller
  // distance, so equal distances keep their arrival order.
  assign ahead = !valid_eff || (ctl.new_dist < distance);

  assign ent.valid    = valid_eff;
  assign ent.value    = value;
  assign ent.distance = distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= next_ent.valid;
    end else if (ctl.insert) begin
      if (ahead && prev_before) begin
        valid <= prev_ent.valid && in_limit;
      end else if (ahead) begin
        valid <= in_limit;
      end else begin
        valid <= valid_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      value    <= next_ent.value;
      distance <= next_ent.distance;
    end else if (ctl.insert && ahead) begin
      if (prev_before) begin
        value    <= prev_ent.value;
        distance <= prev_ent.distance;
      end else begin
        value    <= ctl.new_value;
        distance <= ctl.new_dist;
      end
    end
  end

endmodule

// File: hw/rtl/k_closest_to_target_select_core.sv
// Keeps the keep_count samples of a set that lie closest to target_value and
// reports them in ascending distance, equal distances in arrival order. A
// sample is taken whenever start is high and busy is low, so a set streams in at
// one word per cycle; each sample is placed by a row of compare-and-shift
// cells, one per possible kept entry. The sample marked last_item is placed
// like any other, and then the row drains toward its head: one result word a
// cycle appears under result_strobe for each kept entry (at least one, at most
// the smaller of keep_count and MAX_KEEP), final_result marks the last one,
// and busy stays high meanwhile. Results cannot be held off; they must be
// taken in the cycle they appear.
// Configuration may be written only while busy is low.
module k_closest_to_target_select_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [kcs_pkg::REG_INDEX_BITS-1:0]  reg_index,
  input  logic [kcs_pkg::VALUE_BITS-1:0]      write_data,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [kcs_pkg::VALUE_BITS-1:0] sample_value,
  input  logic                                last_item,
  output logic                                result_strobe,
  output logic signed [kcs_pkg::VALUE_BITS-1:0] chosen_value,
  output logic [kcs_pkg::VALUE_BITS-1:0]      chosen_distance,
  output logic                                final_result
);

  logic signed [kcs_pkg::VALUE_BITS-1:0] target_value;
  logic [kcs_pkg::KEEP_BITS-1:0]         keep_count;
  logic                                  draining;
  logic                                  draining_next;
  logic                                  accept;
  logic signed [kcs_pkg::VALUE_BITS:0]   diff;
  logic [kcs_pkg::VALUE_BITS:0]          diff_abs;
  kcs_pkg::kcs_ctl_t                     ctl;
  kcs_pkg::kcs_entry_t                   link [kcs_pkg::MAX_KEEP+1];
  kcs_pkg::kcs_entry_t                   left_ent [kcs_pkg::MAX_KEEP];
  logic                                  ahead [kcs_pkg::MAX_KEEP];
  logic                                  left_before [kcs_pkg::MAX_KEEP];
  logic                                  in_limit [kcs_pkg::MAX_KEEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value <= '0;
      keep_count   <= kcs_pkg::KEEP_BITS'(1);
    end else if (write_enable) begin
      case (kcs_pkg::kcs_reg_t'(reg_index))
        kcs_pkg::REG_TARGET: target_value <= write_data;
        kcs_pkg::REG_KEEP:   keep_count   <= write_data[kcs_pkg::KEEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;

  // Exact difference needs one extra bit; its magnitude always fits back
  // into VALUE_BITS unsigned bits.
  assign diff = {sample_value[kcs_pkg::VALUE_BITS-1], sample_value}
              - {target_value[kcs_pkg::VALUE_BITS-1], target_value};
  assign diff_abs = diff[kcs_pkg::VALUE_BITS] ? -diff : diff;

  assign ctl.insert    = accept;
  assign ctl.drain     = draining;
  assign ctl.new_value = sample_value;
  assign ctl.new_dist  = diff_abs[kcs_pkg::VALUE_BITS-1:0];

  assign link[kcs_pkg::MAX_KEEP] = '0;

  for (genvar g = 0; g < kcs_pkg::MAX_KEEP; g++) begin : g_cell
    // A keep count of zero behaves as one; counts past the row clamp.
    assign in_limit[g] = (g == 0) || (int'(keep_count) > g);

    if (g == 0) begin : g_head
      assign left_before[g] = 1'b0;
      assign left_ent[g]    = '0;
    end else begin : g_body
      assign left_before[g] = ahead[g-1];
      assign left_ent[g]    = link[g-1];
    end

    kcs_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .in_limit    (in_limit[g]),
      .prev_before (left_before[g]),
      .prev_ent    (left_ent[g]),
      .next_ent    (link[g+1]),
      .ent         (link[g]),
      .ahead       (ahead[g])
    );
  end

  always_comb begin
    draining_next = draining;
    if (draining) begin
      draining_next = link[1].valid;
    end else if (accept && last_item) begin
      draining_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else begin
      draining <= draining_next;
    end
  end

  assign busy            = draining;
  assign result_strobe   = draining;
  assign chosen_value    = link[0].value;
  assign chosen_distance = link[0].distance;
  assign final_result    = !link[1].valid;

endmodule

// File: hw/rtl/kcs_checker.sv
module kcs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_item,
  input logic result_strobe,
  input logic final_result
);

  // An ordinary sample gives no word in the next cycle.
  a_quiet_after_plain: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_item |=> !result_strobe)
    else $error("result word after a sample that did not end a set");

  // The end of a set always yields at least one word right away.
  a_emit_after_last: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_item |=> result_strobe)
    else $error("no result word after the last sample of a set");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    result_strobe && final_result |=> !result_strobe)
    else $error("result word after the final word of a set");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !final_result |=> result_strobe)
    else $error("result burst stopped before its final word");

  a_burst_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_strobe) |-> $past(start && !busy && last_item))
    else $error("result burst started without a set ending");

endmodule

bind k_closest_to_target_select_core kcs_checker u_kcs_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .last_item     (last_item),
  .result_strobe (result_strobe),
  .final_result  (final_result)
);
